/* src/kli_pkg.sv */
// kli_pkg: shared types and constants of the keyframe linear interpolator
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package kli_pkg;

   localparam int unsigned MaxKeysDefault = 256;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CountWidth = 9;
   localparam int unsigned FrameWidth = 8;
   localparam int unsigned BlendWidth = 17;
   localparam int unsigned FracBits = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned NumComps = 3;

   localparam logic [BlendWidth-1:0] BlendOne = BlendWidth'(1 << FracBits);

   // register indexes of the configuration port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_TIME = 2'd0,
      CSR_END_TIME   = 2'd1,
      CSR_KEY_COUNT  = 2'd2
   } csr_index_type;

   // request actions
   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASS,
      ST_RD_A,
      ST_RD_B,
      ST_CMP,
      ST_DIV,
      ST_V0,
      ST_V1,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic seg_zero;
      logic seg_last;
      logic search_init;
      logic rd_hi;
      logic grab_ta;
      logic step;
      logic found;
      logic div_step;
      logic val_hi;
      logic grab_v0;
      logic diff;
      logic mul;
      logic acc;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_lt2;
      logic t_lt_start;
      logic t_gt_end;
      logic more;
      logic hit;
      logic div_last;
      logic comp_last;
   } status_type;

endpackage

/* src/kli_if.sv */
// kli_req_if and kli_rsp_if: valid/ready channels of the interpolator
// depends on kli_pkg for field widths
interface kli_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [kli_pkg::FrameWidth-1:0] key_index;
   logic [kli_pkg::TimeWidth-1:0] key_time;
   logic signed [kli_pkg::ValueWidth-1:0] key_x;
   logic signed [kli_pkg::ValueWidth-1:0] key_y;
   logic signed [kli_pkg::ValueWidth-1:0] key_z;
   logic [kli_pkg::TimeWidth-1:0] sample_time;

   modport source (output valid, action, key_index, key_time, key_x, key_y, key_z,
                   sample_time, input ready);
   modport sink (input valid, action, key_index, key_time, key_x, key_y, key_z,
                 sample_time, output ready);
endinterface

interface kli_rsp_if;
   logic valid;
   logic ready;
   logic signed [kli_pkg::ValueWidth-1:0] out_x;
   logic signed [kli_pkg::ValueWidth-1:0] out_y;
   logic signed [kli_pkg::ValueWidth-1:0] out_z;
   logic [kli_pkg::FrameWidth-1:0] frame_index;
   logic [kli_pkg::BlendWidth-1:0] blend;

   modport source (output valid, out_x, out_y, out_z, frame_index, blend, input ready);
   modport sink (input valid, out_x, out_y, out_z, frame_index, blend, output ready);
endinterface

/* src/kli_ctrl.sv */
// kli_ctrl: controller state machine of the interpolator
// depends on kli_pkg; drives the datapath by cmd_type and reads status_type
module kli_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kli_pkg::cmd_type     cmd,
   input  kli_pkg::status_type  status
);
   import kli_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // state and output word valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_action == ACT_SAMPLE) begin
                  cmd.start = 1'b1;
                  state_in = ST_CLASS;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_CLASS: begin
            if (status.n_lt2 || status.t_lt_start) begin
               cmd.seg_zero = 1'b1;
               state_in = ST_V0;
            end else if (status.t_gt_end) begin
               cmd.seg_last = 1'b1;
               state_in = ST_V0;
            end else begin
               cmd.search_init = 1'b1;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            if (status.more) begin
               state_in = ST_RD_B;
            end else begin
               cmd.seg_last = 1'b1;
               state_in = ST_V0;
            end
         end
         ST_RD_B: begin
            cmd.grab_ta = 1'b1;
            cmd.rd_hi = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.hit) begin
               cmd.found = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RD_A;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_V0;
            end
         end
         ST_V0: begin
            state_in = ST_V1;
         end
         ST_V1: begin
            cmd.grab_v0 = 1'b1;
            cmd.val_hi = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            state_in = status.comp_last ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/kli_dp.sv */
// kli_dp: datapath of the interpolator: key tables, search index, divider, lerp
// depends on kli_pkg; commanded by kli_ctrl
module kli_dp #(
   parameter int unsigned MAX_KEYS = kli_pkg::MaxKeysDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [kli_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [kli_pkg::CsrDataWidth-1:0]      csr_wdata,
   input  logic [kli_pkg::FrameWidth-1:0]        req_key_index,
   input  logic [kli_pkg::TimeWidth-1:0]         req_key_time,
   input  logic signed [kli_pkg::ValueWidth-1:0] req_key_x,
   input  logic signed [kli_pkg::ValueWidth-1:0] req_key_y,
   input  logic signed [kli_pkg::ValueWidth-1:0] req_key_z,
   input  logic [kli_pkg::TimeWidth-1:0]         req_sample_time,
   input  kli_pkg::cmd_type                      cmd,
   output kli_pkg::status_type                   status,
   output logic signed [kli_pkg::ValueWidth-1:0] rsp_out_x,
   output logic signed [kli_pkg::ValueWidth-1:0] rsp_out_y,
   output logic signed [kli_pkg::ValueWidth-1:0] rsp_out_z,
   output logic [kli_pkg::FrameWidth-1:0]        rsp_frame_index,
   output logic [kli_pkg::BlendWidth-1:0]        rsp_blend
);
   import kli_pkg::*;

   localparam int unsigned KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int unsigned NW = KW + 1;
   localparam int unsigned VW3 = NumComps * ValueWidth;
   localparam int unsigned DW = ValueWidth + 1;
   localparam int unsigned PW = DW + BlendWidth + 1;

   // configuration registers
   logic [TimeWidth-1:0] start_time_ff, end_time_ff;
   logic [CountWidth-1:0] key_count_ff;

   // key tables
   logic [TimeWidth-1:0] time_mem [MAX_KEYS];
   logic [VW3-1:0] val_mem [MAX_KEYS];
   logic [TimeWidth-1:0] time_q_ff;
   logic [VW3-1:0] val_q_ff;
   logic [KW-1:0] time_addr, val_addr;

   // search and segment state
   logic [TimeWidth-1:0] t_ff, last_t_ff, ta_ff;
   logic [KW-1:0] idx_ff, last_idx_ff, seg_ff, hi_ff;
   logic [NW-1:0] n_eff;
   logic [NW-1:0] idx_next;

   // divider
   logic [TimeWidth:0] rem_ff;
   logic [TimeWidth-1:0] den_ff;
   logic [TimeWidth:0] rem_sh;
   logic [3:0] div_cnt_ff;
   logic [BlendWidth-1:0] blend_ff;

   // lerp
   logic signed [ValueWidth-1:0] v0_ff [NumComps];
   logic signed [DW-1:0] diff_ff [NumComps];
   logic signed [ValueWidth-1:0] res_ff [NumComps];
   logic signed [PW-1:0] prod_ff;
   logic [1:0] comp_ff;
   logic signed [PW-FracBits-1:0] sum;

   // output word
   logic signed [ValueWidth-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [FrameWidth-1:0] frame_ff;
   logic [BlendWidth-1:0] out_blend_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         end_time_ff <= '0;
         key_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_TIME: start_time_ff <= csr_wdata;
            CSR_END_TIME:   end_time_ff <= csr_wdata;
            CSR_KEY_COUNT:  key_count_ff <= csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // effective key count, capped at the table depth
   assign n_eff = (32'(key_count_ff) < MAX_KEYS) ? NW'(key_count_ff) : NW'(MAX_KEYS);
   assign idx_next = NW'(idx_ff) + NW'(1);

   // table read addresses
   assign time_addr = cmd.rd_hi ? KW'(idx_next) : idx_ff;
   assign val_addr = cmd.val_hi ? hi_ff : seg_ff;

   // key tables: written by load words, read one address a cycle
   always_ff @(posedge clock) begin
      if (cmd.load && (32'(req_key_index) < MAX_KEYS)) begin
         time_mem[KW'(req_key_index)] <= req_key_time;
         val_mem[KW'(req_key_index)] <= {req_key_z, req_key_y, req_key_x};
      end
      time_q_ff <= time_mem[time_addr];
      val_q_ff <= val_mem[val_addr];
   end

   // status to the controller
   always_comb begin
      status.n_lt2 = (n_eff < NW'(2));
      status.t_lt_start = (t_ff < start_time_ff);
      status.t_gt_end = (t_ff > end_time_ff);
      status.more = (idx_next < n_eff);
      status.hit = (t_ff >= ta_ff) && (t_ff < time_q_ff);
      status.div_last = (div_cnt_ff == 4'(FracBits - 1));
      status.comp_last = (comp_ff == 2'(NumComps - 1));
   end

   // cached search state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= '0;
         last_t_ff <= '0;
      end else if (cmd.search_init) begin
         last_t_ff <= t_ff;
         if (t_ff < last_t_ff) begin
            last_idx_ff <= '0;
         end
      end else if (cmd.found) begin
         last_idx_ff <= idx_ff;
      end
   end

   // sample time, search index and segment choice
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         t_ff <= req_sample_time;
      end
      if (cmd.search_init) begin
         idx_ff <= (t_ff < last_t_ff) ? '0 : last_idx_ff;
      end else if (cmd.step) begin
         idx_ff <= KW'(idx_next);
      end
      if (cmd.grab_ta) begin
         ta_ff <= time_q_ff;
      end
      if (cmd.seg_zero) begin
         seg_ff <= '0;
         hi_ff <= status.n_lt2 ? '0 : KW'(1);
         blend_ff <= '0;
      end else if (cmd.seg_last) begin
         seg_ff <= KW'(n_eff - NW'(2));
         hi_ff <= KW'(n_eff - NW'(1));
         blend_ff <= BlendOne;
      end else if (cmd.found) begin
         seg_ff <= idx_ff;
         hi_ff <= KW'(idx_next);
         blend_ff <= '0;
      end else if (cmd.div_step) begin
         blend_ff <= {blend_ff[BlendWidth-2:0], (rem_sh >= {1'b0, den_ff})};
      end
   end

   // restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff[TimeWidth-1:0], 1'b0};
   always_ff @(posedge clock) begin
      if (cmd.found) begin
         rem_ff <= {1'b0, t_ff - ta_ff};
         den_ff <= time_q_ff - ta_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= (rem_sh >= {1'b0, den_ff}) ? rem_sh - {1'b0, den_ff} : rem_sh;
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
   end

   // lerp, one component at a time through a shared multiplier
   assign sum = (PW-FracBits)'(prod_ff >>> FracBits) + (PW-FracBits)'(v0_ff[comp_ff]);
   always_ff @(posedge clock) begin
      if (cmd.grab_v0) begin
         for (int c = 0; c < NumComps; c++) begin
            v0_ff[c] <= val_q_ff[c*ValueWidth +: ValueWidth];
         end
      end
      if (cmd.diff) begin
         for (int c = 0; c < NumComps; c++) begin
            diff_ff[c] <= DW'($signed(val_q_ff[c*ValueWidth +: ValueWidth]))
                        - DW'(v0_ff[c]);
         end
         comp_ff <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= diff_ff[comp_ff] * $signed({1'b0, blend_ff});
      end
      if (cmd.acc) begin
         res_ff[comp_ff] <= sum[ValueWidth-1:0];
         comp_ff <= comp_ff + 2'd1;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_x_ff <= res_ff[0];
         out_y_ff <= res_ff[1];
         out_z_ff <= res_ff[2];
         frame_ff <= FrameWidth'(seg_ff);
         out_blend_ff <= blend_ff;
      end
   end

   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;
   assign rsp_frame_index = frame_ff;
   assign rsp_blend = out_blend_ff;

endmodule

/* src/keyframe_linear_interpolator.sv */
// keyframe_linear_interpolator: piecewise-linear keyframe sampler, top level
// depends on kli_pkg, kli_if, kli_ctrl and kli_dp
// a load word is written to the tables and the controller stays idle; a sample word is classified,
// scanned from the cached index unless it lies outside the key range, divided when a segment holds
// the time, then read, blended per component and registered in the output word
// throughput: one word in flight; the output register frees the input side
// reset: synchronous, clears configuration, search cache and control; tables keep data
module keyframe_linear_interpolator #(
   parameter int unsigned MAX_KEYS = kli_pkg::MaxKeysDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   kli_req_if.sink                           req_if,
   kli_rsp_if.source                         rsp_if,
   input  logic                              csr_write,
   input  logic [kli_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [kli_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import kli_pkg::*;

   cmd_type cmd;
   status_type status;

   // controller
   kli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath
   kli_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_key_index   (req_if.key_index),
      .req_key_time    (req_if.key_time),
      .req_key_x       (req_if.key_x),
      .req_key_y       (req_if.key_y),
      .req_key_z       (req_if.key_z),
      .req_sample_time (req_if.sample_time),
      .cmd             (cmd),
      .status          (status),
      .rsp_out_x       (rsp_if.out_x),
      .rsp_out_y       (rsp_if.out_y),
      .rsp_out_z       (rsp_if.out_z),
      .rsp_frame_index (rsp_if.frame_index),
      .rsp_blend       (rsp_if.blend)
   );

endmodule

/* src/kli_checker.sv */
// kli_checker: port-level assertions of the interpolator
// depends on kli_pkg; bound to keyframe_linear_interpolator
module kli_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_action,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [kli_pkg::BlendWidth-1:0]  rsp_blend
);
   import kli_pkg::*;

   // a pending word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a load word produces no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("result after load word");

   // a sample result is not visible right after acceptance
   a_sample_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_SAMPLE && !rsp_valid |=> !rsp_valid)
      else $error("sample result too early");

   // blend never exceeds one
   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_blend <= BlendOne)
      else $error("blend above one");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .req_action (req_if.action),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_blend  (rsp_if.blend)
);
